// ----- rtl/core/pbl_pkg.sv -----
`timescale 1ns / 1ps

package pbl_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DEPTH_DEF   = 4096;
    localparam int MAX_QUALITY_DEF = 93;

    localparam int SUM_W  = 32;
    localparam int Q_W    = 7;     // quality index, at most MAX_QUALITY (93 by default)
    localparam int INC_W  = 17;    // signed table increment, down to -65536
    localparam int CODE_W = 3;
    localparam int INDEL_W = 10;

    localparam logic [INDEL_W-1:0] INDEL_MAX = 10'd1023;

    // ASCII characters the parser reacts to
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] PHRED_OFFSET = 8'd33;

    // Mismatch term: 1024*ln(p/3) in 16-bit fraction fixed point
    localparam logic [31:0] MIS_SLOPE = 32'd15452387;
    localparam logic [31:0] MIS_BASE  = 32'd73726623;
    localparam logic [31:0] MIS_ROUND = 32'd32768;

    typedef enum logic [1:0] {
        OP_BASE = 2'd0,
        OP_QUAL = 2'd1,
        OP_END  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_CARET  = 2'd1,
        MODE_DIGITS = 2'd2,
        MODE_SKIP   = 2'd3
    } mode_t;

    typedef enum logic [CODE_W-1:0] {
        CODE_A     = 3'd0,
        CODE_T     = 3'd1,
        CODE_G     = 3'd2,
        CODE_C     = 3'd3,
        CODE_OTHER = 3'd4
    } base_code_t;

    typedef logic signed [SUM_W-1:0] score_t;
    typedef logic signed [INC_W-1:0] inc_t;

    // Front end to scoring stage
    typedef struct packed {
        logic           pop;
        logic           end_pos;
        logic           err;
        logic [Q_W-1:0] q;
    } pbl_item_t;

    // Scoring stage to normalisation
    typedef struct packed {
        logic   valid;
        logic   err;
        score_t a;
        score_t t;
        score_t g;
        score_t c;
    } pbl_snap_t;

    function automatic base_code_t base_code(input logic [7:0] ch);
        base_code_t code;
        unique case (ch)
            8'h41, 8'h61: code = CODE_A;
            8'h54, 8'h74: code = CODE_T;
            8'h47, 8'h67: code = CODE_G;
            8'h43, 8'h63: code = CODE_C;
            default:      code = CODE_OTHER;
        endcase
        return code;
    endfunction

    // round(1024*ln(1-p)), quality zero floored at -64 nat
    function automatic inc_t match_val(input logic [Q_W-1:0] q);
        inc_t v;
        unique case (q)
            7'd0:  v = -17'sd65536;
            7'd1:  v = -17'sd1619;
            7'd2:  v = -17'sd1021;
            7'd3:  v = -17'sd712;
            7'd4:  v = -17'sd520;
            7'd5:  v = -17'sd389;
            7'd6:  v = -17'sd296;
            7'd7:  v = -17'sd228;
            7'd8:  v = -17'sd177;
            7'd9:  v = -17'sd138;
            7'd10: v = -17'sd108;
            7'd11: v = -17'sd85;
            7'd12: v = -17'sd67;
            7'd13: v = -17'sd53;
            7'd14: v = -17'sd42;
            7'd15: v = -17'sd33;
            7'd16: v = -17'sd26;
            7'd17: v = -17'sd21;
            7'd18: v = -17'sd16;
            7'd19: v = -17'sd13;
            7'd20: v = -17'sd10;
            7'd21: v = -17'sd8;
            7'd22: v = -17'sd6;
            7'd23: v = -17'sd5;
            7'd24: v = -17'sd4;
            7'd25: v = -17'sd3;
            7'd26: v = -17'sd3;
            7'd27: v = -17'sd2;
            7'd28: v = -17'sd2;
            7'd29, 7'd30, 7'd31, 7'd32, 7'd33: v = -17'sd1;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    // {saturated, result}; increments are never positive
    function automatic logic [SUM_W:0] sat_add(input score_t s, input inc_t v);
        logic signed [SUM_W:0] r;
        r = (SUM_W+1)'(s) + (SUM_W+1)'(v);
        if (r[SUM_W] != r[SUM_W-1]) begin
            return {1'b1, 1'b1, {(SUM_W-1){1'b0}}};
        end
        return {1'b0, r[SUM_W-1:0]};
    endfunction

    function automatic score_t max2(input score_t x, input score_t y);
        return (x > y) ? x : y;
    endfunction

endpackage

// ----- rtl/core/pbl_front.sv -----
`timescale 1ns / 1ps

module pbl_front #(
    parameter int MAX_DEPTH   = pbl_pkg::MAX_DEPTH_DEF,
    parameter int MAX_QUALITY = pbl_pkg::MAX_QUALITY_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         accept,
    input  logic [1:0]                   operation,
    input  logic [7:0]                   symbol,
    input  logic [7:0]                   ref_base,
    output pbl_pkg::pbl_item_t           item,
    output logic [pbl_pkg::CODE_W-1:0]   code
);

    localparam int PW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [PW-1:0] DEPTH_P = PW'(MAX_DEPTH);
    localparam logic [7:0]    QMAX_8  = 8'(MAX_QUALITY);

    pbl_pkg::mode_t                mode_reg, mode_next;
    logic [pbl_pkg::INDEL_W-1:0]   indel_reg, indel_next;
    logic [PW-1:0]                 wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic                          perr_reg, perr_next;
    pbl_pkg::pbl_item_t            item_reg, item_next;
    logic [pbl_pkg::CODE_W-1:0]    rd_reg;
    logic [pbl_pkg::CODE_W-1:0]    queue_mem [MAX_DEPTH];

    pbl_pkg::op_t                  op;
    logic [7:0]                    ch_sub;
    logic                          is_digit;
    logic [13:0]                   indel_acc;
    logic [7:0]                    q_raw;
    logic                          do_normal;
    logic                          push;
    logic                          pop;

    assign op       = pbl_pkg::op_t'(operation);
    assign ch_sub   = (symbol == pbl_pkg::CH_DOT || symbol == pbl_pkg::CH_COMMA)
                      ? ref_base : symbol;
    assign is_digit = (symbol >= pbl_pkg::CH_ZERO) && (symbol <= pbl_pkg::CH_NINE);
    assign indel_acc = {1'b0, indel_reg, 3'b000} + {3'b000, indel_reg, 1'b0}
                       + {10'd0, 4'(symbol - pbl_pkg::CH_ZERO)};
    assign q_raw    = (symbol < pbl_pkg::PHRED_OFFSET) ? 8'd0 : symbol - pbl_pkg::PHRED_OFFSET;

    always_comb begin
        mode_next  = mode_reg;
        indel_next = indel_reg;
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        perr_next  = perr_reg;
        item_next  = '0;
        do_normal  = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;

        if (accept) begin
            unique case (op)
                pbl_pkg::OP_BASE: begin
                    unique case (mode_reg)
                        pbl_pkg::MODE_CARET: begin
                            mode_next = pbl_pkg::MODE_NORMAL;
                        end
                        pbl_pkg::MODE_DIGITS: begin
                            if (is_digit) begin
                                indel_next = (indel_acc > 14'(pbl_pkg::INDEL_MAX))
                                             ? pbl_pkg::INDEL_MAX
                                             : indel_acc[pbl_pkg::INDEL_W-1:0];
                            end else if (indel_reg == '0) begin
                                mode_next = pbl_pkg::MODE_NORMAL;
                                do_normal = 1'b1;
                            end else begin
                                indel_next = indel_reg - 1'b1;
                                mode_next  = (indel_reg != 10'd1) ? pbl_pkg::MODE_SKIP
                                                                  : pbl_pkg::MODE_NORMAL;
                            end
                        end
                        pbl_pkg::MODE_SKIP: begin
                            if (indel_reg > 10'd1) begin
                                indel_next = indel_reg - 1'b1;
                            end else begin
                                indel_next = '0;
                                mode_next  = pbl_pkg::MODE_NORMAL;
                            end
                        end
                        pbl_pkg::MODE_NORMAL: begin
                            do_normal = 1'b1;
                        end
                    endcase
                end
                pbl_pkg::OP_QUAL: begin
                    if (rptr_reg < wptr_reg) begin
                        pop       = 1'b1;
                        rptr_next = rptr_reg + 1'b1;
                    end
                    item_next.pop = pop;
                    item_next.q   = (q_raw > QMAX_8) ? QMAX_8[pbl_pkg::Q_W-1:0]
                                                     : q_raw[pbl_pkg::Q_W-1:0];
                end
                pbl_pkg::OP_END: begin
                    mode_next         = pbl_pkg::MODE_NORMAL;
                    indel_next        = '0;
                    wptr_next         = '0;
                    rptr_next         = '0;
                    perr_next         = 1'b0;
                    item_next.end_pos = 1'b1;
                    item_next.err     = perr_reg;
                end
                pbl_pkg::OP_NONE: begin
                end
            endcase
        end

        if (do_normal) begin
            priority if (ch_sub == pbl_pkg::CH_DOLLAR) begin
            end else if (ch_sub == pbl_pkg::CH_CARET) begin
                mode_next = pbl_pkg::MODE_CARET;
            end else if (ch_sub == pbl_pkg::CH_PLUS || ch_sub == pbl_pkg::CH_MINUS) begin
                mode_next  = pbl_pkg::MODE_DIGITS;
                indel_next = '0;
            end else if (wptr_reg == DEPTH_P) begin
                perr_next = 1'b1;
            end else begin
                push      = 1'b1;
                wptr_next = wptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= pbl_pkg::MODE_NORMAL;
            indel_reg <= '0;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            perr_reg  <= 1'b0;
            item_reg  <= '0;
        end else if (adv) begin
            mode_reg  <= mode_next;
            indel_reg <= indel_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            perr_reg  <= perr_next;
            item_reg  <= item_next;
        end
    end

    // Queue storage: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wptr_reg[AW-1:0]] <= pbl_pkg::base_code(ch_sub);
        end
        if (pop) begin
            rd_reg <= queue_mem[rptr_reg[AW-1:0]];
        end
    end

    assign item = item_reg;
    assign code = rd_reg;

endmodule

// ----- rtl/core/pbl_score.sv -----
`timescale 1ns / 1ps

module pbl_score (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  pbl_pkg::pbl_item_t          item,
    input  logic [pbl_pkg::CODE_W-1:0]  code,
    output pbl_pkg::pbl_snap_t          snap
);

    logic                 pop_reg, end_reg, err_reg;
    logic [1:0]           lane_reg;
    pbl_pkg::inc_t        hit_reg, miss_reg;
    logic [31:0]          mis_acc;
    pbl_pkg::inc_t        miss_val;

    pbl_pkg::score_t      sum_reg  [4];
    pbl_pkg::score_t      sum_next [4];
    logic                 serr_reg, serr_next;
    pbl_pkg::pbl_snap_t   snap_reg, snap_next;
    logic [pbl_pkg::SUM_W:0] add_res [4];

    assign mis_acc  = 32'(item.q) * pbl_pkg::MIS_SLOPE + pbl_pkg::MIS_BASE
                      + pbl_pkg::MIS_ROUND;
    assign miss_val = -$signed({1'b0, mis_acc[31:16]});

    // Lookup stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pop_reg <= 1'b0;
            end_reg <= 1'b0;
            err_reg <= 1'b0;
        end else if (adv) begin
            pop_reg <= item.pop && (code <= pbl_pkg::CODE_C);
            end_reg <= item.end_pos;
            err_reg <= item.err;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lane_reg <= code[1:0];
            hit_reg  <= pbl_pkg::match_val(item.q);
            miss_reg <= miss_val;
        end
    end

    // Accumulate stage
    always_comb begin
        serr_next = serr_reg;
        snap_next = '0;
        for (int i = 0; i < 4; i++) begin
            add_res[i]  = pbl_pkg::sat_add(sum_reg[i],
                              (lane_reg == 2'(i)) ? hit_reg : miss_reg);
            sum_next[i] = sum_reg[i];
        end
        if (pop_reg) begin
            for (int i = 0; i < 4; i++) begin
                sum_next[i] = add_res[i][pbl_pkg::SUM_W-1:0];
                serr_next   = serr_next | add_res[i][pbl_pkg::SUM_W];
            end
        end
        if (end_reg) begin
            snap_next.valid = 1'b1;
            snap_next.err   = serr_reg | err_reg;
            snap_next.a     = sum_reg[0];
            snap_next.t     = sum_reg[1];
            snap_next.g     = sum_reg[2];
            snap_next.c     = sum_reg[3];
            serr_next       = 1'b0;
            for (int i = 0; i < 4; i++) begin
                sum_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            serr_reg <= 1'b0;
            snap_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (adv) begin
            serr_reg <= serr_next;
            snap_reg <= snap_next;
            for (int i = 0; i < 4; i++) begin
                sum_reg[i] <= sum_next[i];
            end
        end
    end

    assign snap = snap_reg;

endmodule

// ----- rtl/core/pbl_norm.sv -----
`timescale 1ns / 1ps

module pbl_norm (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  pbl_pkg::pbl_snap_t   snap,
    output logic                 m_valid,
    output pbl_pkg::score_t      m_lh_a,
    output pbl_pkg::score_t      m_lh_t,
    output pbl_pkg::score_t      m_lh_g,
    output pbl_pkg::score_t      m_lh_c,
    output logic                 m_overflow
);

    pbl_pkg::pbl_snap_t  hold_reg;
    pbl_pkg::score_t     max_reg;
    logic                valid_reg;
    pbl_pkg::score_t     a_reg, t_reg, g_reg, c_reg;
    logic                ovf_reg;

    // Find the maximum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= '0;
        end else if (adv) begin
            hold_reg <= snap;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            max_reg <= pbl_pkg::max2(pbl_pkg::max2(snap.a, snap.t),
                                     pbl_pkg::max2(snap.g, snap.c));
        end
    end

    // Subtract into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= hold_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg   <= hold_reg.a - max_reg;
            t_reg   <= hold_reg.t - max_reg;
            g_reg   <= hold_reg.g - max_reg;
            c_reg   <= hold_reg.c - max_reg;
            ovf_reg <= hold_reg.err;
        end
    end

    assign m_valid    = valid_reg;
    assign m_lh_a     = a_reg;
    assign m_lh_t     = t_reg;
    assign m_lh_g     = g_reg;
    assign m_lh_c     = c_reg;
    assign m_overflow = ovf_reg;

endmodule

// ----- rtl/core/pileup_base_likelihood_core.sv -----
`timescale 1ns / 1ps
// Throughput: one transaction per clock cycle, stalled only while a result waits on m_ready.
// After acceptance, an end-of-position transaction yields its result through these registered steps:
// parse and queue read, table lookup, accumulate, maximum, subtract into output register.
// Reset: aresetn is synchronous, active low; it clears the parser, queue pointers, sums
// and pipeline valid bits. Queue contents are not cleared; reads only touch entries
// written earlier in the same position.
module pileup_base_likelihood_core #(
    parameter int MAX_DEPTH   = pbl_pkg::MAX_DEPTH_DEF,
    parameter int MAX_QUALITY = pbl_pkg::MAX_QUALITY_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  logic [7:0]            s_symbol,
    input  logic [7:0]            s_ref_base,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_lh_a,
    output logic signed [31:0]    m_lh_t,
    output logic signed [31:0]    m_lh_g,
    output logic signed [31:0]    m_lh_c,
    output logic                  m_overflow
);

    // The pipeline moves as one: every stage advances whenever the output
    // register is empty or its transaction is being taken this cycle.
    logic                          adv;
    logic                          accept;
    pbl_pkg::pbl_item_t            item;
    logic [pbl_pkg::CODE_W-1:0]    code;
    pbl_pkg::pbl_snap_t            snap;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    // Parse base characters, push and pop the base queue, clamp the quality.
    pbl_front #(
        .MAX_DEPTH   (MAX_DEPTH),
        .MAX_QUALITY (MAX_QUALITY)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .accept    (accept),
        .operation (s_operation),
        .symbol    (s_symbol),
        .ref_base  (s_ref_base),
        .item      (item),
        .code      (code)
    );

    // Look up the match and mismatch terms, then add into the four saturating sums;
    // an end marker takes a snapshot of the sums and clears them.
    pbl_score u_score (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .item    (item),
        .code    (code),
        .snap    (snap)
    );

    // Subtract the largest sum from each and hold the result for m_ready.
    pbl_norm u_norm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .snap       (snap),
        .m_valid    (m_valid),
        .m_lh_a     (m_lh_a),
        .m_lh_t     (m_lh_t),
        .m_lh_g     (m_lh_g),
        .m_lh_c     (m_lh_c),
        .m_overflow (m_overflow)
    );

endmodule
